@@ rtl/mfhp_pkg.sv @@
// ----------------------------------------------------------------------------
// mfhp_pkg
// shared types, constants and helpers of the mac frame header parser
// ----------------------------------------------------------------------------
package mfhp_pkg;

    // address modes of the frame control word
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SHORT = 2'd2;

    // fixed header byte positions
    localparam logic [4:0] POS_FC_LO = 5'd0;
    localparam logic [4:0] POS_FC_HI = 5'd1;
    localparam logic [4:0] POS_SEQ   = 5'd2;

    // frame control plus sequence number
    localparam logic [4:0] HDR_FIXED_LEN = 5'd3;
    localparam logic [4:0] HDR_MAX_LEN   = 5'd23;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  frm_kind;
        logic        pend_flag;
        logic        ack_request;
        logic        pan_compress;
        logic [1:0]  dest_mode;
        logic [1:0]  src_mode;
        logic [7:0]  sequence_number;
        logic [15:0] dest_pan;
        logic [63:0] dest_address;
        logic [15:0] src_pan;
        logic [63:0] src_address;
        logic [4:0]  header_length;
    } t_out_item;

    // finished header handed from the front to the queue
    typedef struct packed {
        logic      push;
        t_out_item rec;
    } t_hdr_push;

    // queue status toward the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

    // bytes taken by an address of the given mode
    function automatic logic [3:0] addr_len(input logic [1:0] mode);
        logic [3:0] len;
        if (mode == MODE_NONE) begin
            len = 4'd0;
        end else if (mode == MODE_SHORT) begin
            len = 4'd2;
        end else begin
            len = 4'd8;
        end
        return len;
    endfunction

endpackage

@@ rtl/mac_frame_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// mac_frame_header_parser_unit
// 802.15.4 style mac header parser with a byte front end and result output
// ----------------------------------------------------------------------------
// Frame bytes enter one per transfer, a start flag marking the first byte of
// each frame. While the queue is not full the front end takes one byte every
// cycle and steers it into the frame control word, sequence number,
// destination pan and address, or source pan and address, by its position in
// the header; the source pan is skipped under pan id compression, mode 0
// addresses are absent, mode 2 is short and any other mode is a long 8-byte
// address. On the byte that completes the header a single result carrying
// every decoded field and the header length is pushed into a two-entry queue,
// and bytes are then ignored until the next start flag. A start flag
// mid-header drops the partial header with no result.
// Rate: one byte per cycle. A result is written into the queue at the edge
// that takes its last byte and moves on into the output register once that
// register is free; results leave at up to one per cycle. The input stalls
// only while the queue holds two headers that the output side has not taken.
// ----------------------------------------------------------------------------
module mac_frame_header_parser_unit
    import mfhp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // byte input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // header result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_hdr_push push;
    t_q_status q_status;
    t_out_item q_head;
    logic      pop;
    logic      in_accept;

    // stall on a full queue so a completing byte always has room
    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    // front end: position tracking and field assembly
    mfhp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_push   (push)
    );

    // decoupling queue of finished headers
    mfhp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (q_head)
    );

    // back end: output register for the result transfer
    mfhp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (q_status),
        .i_head      (q_head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_hdr_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.header_length >= HDR_FIXED_LEN &&
                         o_out_data.header_length <= HDR_MAX_LEN))
        else $error("header length out of range");

    a_dest_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.dest_mode == MODE_NONE) |->
            (o_out_data.dest_pan == '0 && o_out_data.dest_address == '0))
        else $error("absent destination carries data");

    a_src_pan_omitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.src_mode == MODE_NONE || o_out_data.pan_compress)) |->
            (o_out_data.src_pan == '0))
        else $error("omitted source pan carries data");
`endif

endmodule

@@ rtl/mfhp_front.sv @@
// ----------------------------------------------------------------------------
// mfhp_front
// byte front end: tracks header position and assembles the header fields
// ----------------------------------------------------------------------------
module mfhp_front
    import mfhp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output t_hdr_push o_push
);

    logic        r_active, n_active;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_cw, n_cw;
    logic [7:0]  r_seq, n_seq;
    logic [15:0] r_dpan, n_dpan;
    logic [63:0] r_daddr, n_daddr;
    logic [15:0] r_span, n_span;
    logic [63:0] r_saddr, n_saddr;

    logic        start;
    logic [4:0]  p;
    logic [4:0]  off, off2, off3;
    logic [3:0]  dlen;
    logic [1:0]  splen;
    logic [3:0]  salen;
    logic [3:0]  n_dlen;
    logic [1:0]  n_splen;
    logic [3:0]  n_salen;
    logic [4:0]  hlen;
    logic        done;
    logic [2:0]  daddr_lane;

    always_comb begin
        // a start flag counts only on an accepted byte
        start = i_accept && i_item.frame_start;
        p     = start ? POS_FC_LO : r_pos;

        // field lengths from the held control word (complete past the fixed bytes)
        dlen  = (r_cw[11:10] == MODE_NONE) ? 4'd0 : 4'd2 + addr_len(r_cw[11:10]);
        splen = (r_cw[15:14] != MODE_NONE && !r_cw[6]) ? 2'd2 : 2'd0;
        salen = addr_len(r_cw[15:14]);

        off        = p - HDR_FIXED_LEN;
        off2       = off - {1'b0, dlen};
        off3       = off2 - {3'b000, splen};
        daddr_lane = off[2:0] - 3'd2;

        n_active = r_active;
        n_pos    = r_pos;
        n_cw     = start ? '0 : r_cw;
        n_seq    = start ? '0 : r_seq;
        n_dpan   = start ? '0 : r_dpan;
        n_daddr  = start ? '0 : r_daddr;
        n_span   = start ? '0 : r_span;
        n_saddr  = start ? '0 : r_saddr;

        if (i_accept && start) begin
            n_active = 1'b1;
        end

        if (i_accept && (start || r_active)) begin
            if (p == POS_FC_LO) begin
                n_cw[7:0] = i_item.data_byte;
            end else if (p == POS_FC_HI) begin
                n_cw[15:8] = i_item.data_byte;
            end else if (p == POS_SEQ) begin
                n_seq = i_item.data_byte;
            end else if (off < {1'b0, dlen}) begin
                if (off < 5'd2) begin
                    n_dpan = n_dpan | (16'(i_item.data_byte) << {off[0], 3'b000});
                end else begin
                    n_daddr = n_daddr | (64'(i_item.data_byte) << {daddr_lane, 3'b000});
                end
            end else if (off2 < {3'b000, splen}) begin
                n_span = n_span | (16'(i_item.data_byte) << {off2[0], 3'b000});
            end else if (off3 < {1'b0, salen}) begin
                n_saddr = n_saddr | (64'(i_item.data_byte) << {off3[2:0], 3'b000});
            end
            n_pos = p + 5'd1;
        end

        // header length from the updated control word
        n_dlen  = (n_cw[11:10] == MODE_NONE) ? 4'd0 : 4'd2 + addr_len(n_cw[11:10]);
        n_splen = (n_cw[15:14] != MODE_NONE && !n_cw[6]) ? 2'd2 : 2'd0;
        n_salen = addr_len(n_cw[15:14]);
        hlen    = HDR_FIXED_LEN + 5'(n_dlen) + 5'(n_splen) + 5'(n_salen);

        done = i_accept && (start || r_active) && (p >= POS_SEQ) && (p + 5'd1 == hlen);
        if (done) begin
            n_active = 1'b0;
        end

        o_push.push                    = done;
        o_push.rec.frm_kind            = n_cw[1:0];
        o_push.rec.pend_flag           = n_cw[4];
        o_push.rec.ack_request         = n_cw[5];
        o_push.rec.pan_compress        = n_cw[6];
        o_push.rec.dest_mode           = n_cw[11:10];
        o_push.rec.src_mode            = n_cw[15:14];
        o_push.rec.sequence_number     = n_seq;
        o_push.rec.dest_pan            = n_dpan;
        o_push.rec.dest_address        = n_daddr;
        o_push.rec.src_pan             = n_span;
        o_push.rec.src_address         = n_saddr;
        o_push.rec.header_length       = hlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_cw     <= '0;
            r_seq    <= '0;
            r_dpan   <= '0;
            r_daddr  <= '0;
            r_span   <= '0;
            r_saddr  <= '0;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_cw     <= n_cw;
            r_seq    <= n_seq;
            r_dpan   <= n_dpan;
            r_daddr  <= n_daddr;
            r_span   <= n_span;
            r_saddr  <= n_saddr;
        end
    end

endmodule

@@ rtl/mfhp_queue.sv @@
// ----------------------------------------------------------------------------
// mfhp_queue
// short queue of finished headers between the front and the output stage
// ----------------------------------------------------------------------------
module mfhp_queue
    import mfhp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_hdr_push i_push,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_out_item o_head
);

    t_out_item              r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    localparam logic [QUEUE_PTR_W-1:0] PtrLast = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CntFull = QUEUE_CNT_W'(QUEUE_DEPTH);

    always_comb begin
        o_status.full      = (r_count == CntFull);
        o_status.not_empty = (r_count != '0);
        o_head             = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntFull)
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> (!o_status.full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_status.not_empty)
        else $error("pop from empty queue");
`endif

endmodule

@@ rtl/mfhp_back.sv @@
// ----------------------------------------------------------------------------
// mfhp_back
// output register stage: drains the queue into the result channel
// ----------------------------------------------------------------------------
module mfhp_back
    import mfhp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_status,
    input  t_out_item i_head,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic      r_valid, n_valid;
    t_out_item r_data;

    always_comb begin
        // refill when empty or when the held result leaves this cycle
        o_pop   = i_status.not_empty && (!r_valid || !i_out_stall);
        n_valid = o_pop || (r_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the mac frame header parser unit
// ----------------------------------------------------------------------------
// The bench sends frame byte streams into the byte channel and checks each
// decoded header on the result channel. The byte stream has two parts. A short
// directed part covers stray bytes after reset, the shortest and a long
// all-ones header, and a header cut off by a new start. A random part follows,
// made mostly of well-formed headers with random frame control words, plus
// truncated headers, trailing payload and stray bytes. A byte-level model of
// the parser runs on every accepted byte and queues the header it expects.
// Both channels pause at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module testbench;
    import mfhp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // frame control word layout
    localparam int FC_PENDING_BIT  = 4;
    localparam int FC_ACK_BIT      = 5;
    localparam int FC_COMPRESS_BIT = 6;
    localparam int DEST_MODE_LSB   = 10;
    localparam int SRC_MODE_LSB    = 14;

    // run shape
    localparam int NUM_PARSED_BYTES = 1600;
    localparam int RESET_CYCLES     = 10;
    localparam int DRAIN_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int MAX_REPORTS      = 100;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // bytes waiting to be sent, headers waiting to come out
    t_in_item  rx_bytes[$];
    t_out_item hdr_expect[$];

    // header model state
    logic [4:0]  hp_pos    = '0;
    logic        hp_active = 1'b0;
    logic [15:0] hp_fc     = '0;
    logic [7:0]  hp_seq    = '0;
    logic [15:0] hp_dpan   = '0;
    logic [63:0] hp_daddr  = '0;
    logic [15:0] hp_span   = '0;
    logic [63:0] hp_saddr  = '0;

    // pacing of both channels
    int send_gap   = 0;
    bit send_calm  = 1'b0;
    int stall_left = 0;
    bit recv_calm  = 1'b0;

    // bookkeeping
    int mismatches     = 0;
    int results_seen   = 0;
    int bytes_accepted = 0;
    int parsed_bytes   = 0;
    int stray_bytes    = 0;
    int cut_frames     = 0;
    int idle_cycles    = 0;

    mac_frame_header_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // header length arithmetic
    // ------------------------------------------------------------------------

    // bytes of an address in the given mode, reserved modes count as long
    function automatic int addr_bytes(input logic [1:0] mode);
        if (mode == MODE_NONE) begin
            return 0;
        end
        return (mode == MODE_SHORT) ? 2 : 8;
    endfunction

    // destination pan plus destination address, both absent in mode none
    function automatic int dest_bytes(input logic [15:0] fc);
        logic [1:0] mode;
        mode = fc[DEST_MODE_LSB +: 2];
        return (mode == MODE_NONE) ? 0 : 2 + addr_bytes(mode);
    endfunction

    // source pan only with a source address and no pan id compression
    function automatic int src_pan_bytes(input logic [15:0] fc);
        return (fc[SRC_MODE_LSB +: 2] != MODE_NONE && !fc[FC_COMPRESS_BIT]) ? 2 : 0;
    endfunction

    function automatic int hdr_bytes(input logic [15:0] fc);
        return 3 + dest_bytes(fc) + src_pan_bytes(fc) + addr_bytes(fc[SRC_MODE_LSB +: 2]);
    endfunction

    // ------------------------------------------------------------------------
    // header model, fed with every accepted byte
    // ------------------------------------------------------------------------
    task automatic parse_byte(input t_in_item it);
        int        p;
        int        off;
        t_out_item hdr;
        // a start flag drops whatever was gathered and opens a new header
        if (it.frame_start) begin
            hp_pos    = '0;
            hp_fc     = '0;
            hp_seq    = '0;
            hp_dpan   = '0;
            hp_daddr  = '0;
            hp_span   = '0;
            hp_saddr  = '0;
            hp_active = 1'b1;
        end
        // idle after reset or after a finished header: byte is ignored
        if (!hp_active) begin
            return;
        end
        p   = hp_pos;
        off = p - 3;
        if (p == POS_FC_LO) begin
            hp_fc[7:0] = it.data_byte;
        end else if (p == POS_FC_HI) begin
            hp_fc[15:8] = it.data_byte;
        end else if (p == POS_SEQ) begin
            hp_seq = it.data_byte;
        end else if (off < dest_bytes(hp_fc)) begin
            // destination pan first, then the address, both little-endian
            if (off < 2) begin
                hp_dpan[8*off +: 8] = it.data_byte;
            end else begin
                hp_daddr[8*(off-2) +: 8] = it.data_byte;
            end
        end else begin
            off -= dest_bytes(hp_fc);
            if (off < src_pan_bytes(hp_fc)) begin
                hp_span[8*off +: 8] = it.data_byte;
            end else begin
                off -= src_pan_bytes(hp_fc);
                if (off < addr_bytes(hp_fc[SRC_MODE_LSB +: 2])) begin
                    hp_saddr[8*off +: 8] = it.data_byte;
                end
            end
        end
        hp_pos = 5'(p + 1);
        // the byte that completes the header produces the one result
        if (p >= POS_SEQ && p + 1 == hdr_bytes(hp_fc)) begin
            hp_active           = 1'b0;
            hdr.frm_kind        = hp_fc[1:0];
            hdr.pend_flag       = hp_fc[FC_PENDING_BIT];
            hdr.ack_request     = hp_fc[FC_ACK_BIT];
            hdr.pan_compress    = hp_fc[FC_COMPRESS_BIT];
            hdr.dest_mode       = hp_fc[DEST_MODE_LSB +: 2];
            hdr.src_mode        = hp_fc[SRC_MODE_LSB +: 2];
            hdr.sequence_number = hp_seq;
            hdr.dest_pan        = hp_dpan;
            hdr.dest_address    = hp_daddr;
            hdr.src_pan         = hp_span;
            hdr.src_address     = hp_saddr;
            hdr.header_length   = 5'(hdr_bytes(hp_fc));
            hdr_expect.push_back(hdr);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------

    // queue the first keep bytes of a header, payload after the fixed part
    task automatic queue_frame(input logic [15:0] fc, input logic [7:0] seq,
                               input int keep, input t_fill fill);
        t_in_item it;
        for (int i = 0; i < keep; i++) begin
            it.frame_start = (i == 0);
            case (i)
                0: begin
                    it.data_byte = fc[7:0];
                end
                1: begin
                    it.data_byte = fc[15:8];
                end
                2: begin
                    it.data_byte = seq;
                end
                default: begin
                    case (fill)
                        FILL_ZERO: it.data_byte = 8'h00;
                        FILL_ONES: it.data_byte = 8'hFF;
                        default:   it.data_byte = 8'($urandom_range(0, 255));
                    endcase
                end
            endcase
            rx_bytes.push_back(it);
        end
        parsed_bytes += keep;
        if (keep < hdr_bytes(fc)) begin
            cut_frames++;
        end
    endtask

    // bytes without a start flag: ignored when idle, else part of the header
    task automatic queue_stray(input int count);
        t_in_item it;
        for (int i = 0; i < count; i++) begin
            it.frame_start = 1'b0;
            it.data_byte   = 8'($urandom_range(0, 255));
            rx_bytes.push_back(it);
        end
        stray_bytes += count;
    endtask

    // wait length for one item, zero during calm stretches
    function automatic int idle_draw(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
                     what, results_seen, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // byte driver: one transfer per item, random gap before the next one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // transfer at this edge goes to the header model
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_in_data);
                bytes_accepted++;
            end
            // payload held while stalled, otherwise load next or idle
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (rx_bytes.size() != 0) begin
                    i_in_data  <= rx_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = idle_draw(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: compares each transfer with the oldest expected header
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : hdr_monitor
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (hdr_expect.size() == 0) begin
                    report_mismatch("unexpected header, length", '0,
                                    64'(o_out_data.header_length));
                end else begin
                    want = hdr_expect.pop_front();
                    if (o_out_data.frm_kind !== want.frm_kind)
                        report_mismatch("frm_kind", 64'(want.frm_kind),
                                        64'(o_out_data.frm_kind));
                    if (o_out_data.pend_flag !== want.pend_flag)
                        report_mismatch("pend_flag", 64'(want.pend_flag),
                                        64'(o_out_data.pend_flag));
                    if (o_out_data.ack_request !== want.ack_request)
                        report_mismatch("ack_request", 64'(want.ack_request),
                                        64'(o_out_data.ack_request));
                    if (o_out_data.pan_compress !== want.pan_compress)
                        report_mismatch("pan_compress", 64'(want.pan_compress),
                                        64'(o_out_data.pan_compress));
                    if (o_out_data.dest_mode !== want.dest_mode)
                        report_mismatch("dest_mode", 64'(want.dest_mode),
                                        64'(o_out_data.dest_mode));
                    if (o_out_data.src_mode !== want.src_mode)
                        report_mismatch("src_mode", 64'(want.src_mode),
                                        64'(o_out_data.src_mode));
                    if (o_out_data.sequence_number !== want.sequence_number)
                        report_mismatch("sequence_number", 64'(want.sequence_number),
                                        64'(o_out_data.sequence_number));
                    if (o_out_data.dest_pan !== want.dest_pan)
                        report_mismatch("dest_pan", 64'(want.dest_pan),
                                        64'(o_out_data.dest_pan));
                    if (o_out_data.dest_address !== want.dest_address)
                        report_mismatch("dest_address", want.dest_address,
                                        o_out_data.dest_address);
                    if (o_out_data.src_pan !== want.src_pan)
                        report_mismatch("src_pan", 64'(want.src_pan),
                                        64'(o_out_data.src_pan));
                    if (o_out_data.src_address !== want.src_address)
                        report_mismatch("src_address", want.src_address,
                                        o_out_data.src_address);
                    if (o_out_data.header_length !== want.header_length)
                        report_mismatch("header_length", 64'(want.header_length),
                                        64'(o_out_data.header_length));
                end
                results_seen++;
                // stall count for the next result
                stall_left = idle_draw(recv_calm);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left != 0);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [15:0] fc;
        logic [7:0]  seq;
        int          len;
        int          kind;

        // directed: stray bytes right after reset are ignored
        queue_stray(2);
        // shortest header, every field zero
        queue_frame(16'h0000, 8'h00, hdr_bytes(16'h0000), FILL_ZERO);
        // trailing payload after a complete header is ignored
        queue_stray(1);
        // all ones: reserved long modes on both sides, compressed source pan
        queue_frame(16'hFFFF, 8'hFF, hdr_bytes(16'hFFFF), FILL_ONES);
        // short destination cut off mid-pan, restarted by the next start
        fc = '0;
        fc[DEST_MODE_LSB +: 2] = MODE_SHORT;
        queue_frame(fc, 8'h5A, 4, FILL_ZERO);

        // random: mostly complete headers, some cut, some with stray bytes
        while (parsed_bytes < NUM_PARSED_BYTES) begin
            fc   = 16'($urandom_range(0, 16'hFFFF));
            seq  = 8'($urandom_range(0, 255));
            len  = hdr_bytes(fc);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                queue_frame(fc, seq, len, FILL_RANDOM);
            end else if (kind == 7) begin
                queue_frame(fc, seq, $urandom_range(1, len - 1), FILL_RANDOM);
            end else if (kind == 8) begin
                queue_frame(fc, seq, len, FILL_RANDOM);
                queue_stray($urandom_range(1, 6));
            end else begin
                queue_stray($urandom_range(1, 4));
            end
        end

        // synchronous reset, released on a clock edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every byte sent, every expected header back, then a short drain
        while (rx_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (hdr_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (hdr_expect.size() != 0) begin
            report_mismatch("headers never delivered", 64'(hdr_expect.size()), '0);
        end

        $display("covered %0d headers checked from %0d bytes sent (%0d header bytes,",
                 results_seen, bytes_accepted, parsed_bytes);
        $display("%0d stray or trailing bytes, %0d cut-off headers), %0d mismatches",
                 stray_bytes, cut_frames, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mfhp_pkg.sv
rtl/mfhp_front.sv
rtl/mfhp_queue.sv
rtl/mfhp_back.sv
rtl/mac_frame_header_parser_unit.sv
sim/testbench.sv
